/* src/wsc_pkg.sv */
package wsc_pkg;

    // mode levels
    localparam logic [1:0] MODE_LOW      = 2'd0;
    localparam logic [1:0] MODE_HIGH     = 2'd1;
    localparam logic [1:0] MODE_INTERVAL = 2'd2;
    localparam logic [1:0] MODE_OFF      = 2'd3;

    // interval levels
    localparam logic [1:0] INT_SHORT = 2'd0;
    localparam logic [1:0] INT_MID   = 2'd1;
    localparam logic [1:0] INT_LONG  = 2'd2;

    // sweep phases
    localparam logic [1:0] PH_STOP = 2'd0;
    localparam logic [1:0] PH_RISE = 2'd1;
    localparam logic [1:0] PH_FALL = 2'd2;

    // configuration register map
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 15;
    localparam logic [CFG_AW-1:0] CFG_POS_MIN    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_POS_MAX    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_STEP_LOW   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_STEP_HIGH  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_WAIT_SHORT = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_WAIT_MID   = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_WAIT_LONG  = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_HYSTERESIS = 3'd7;

    // register reset values
    localparam logic [14:0] POS_MIN_RST    = 15'd16000;
    localparam logic [14:0] POS_MAX_RST    = 15'd28800;
    localparam logic [11:0] STEP_LOW_RST   = 12'd917;
    localparam logic [11:0] STEP_HIGH_RST  = 12'd1375;
    localparam logic [7:0]  WAIT_SHORT_RST = 8'd38;
    localparam logic [7:0]  WAIT_MID_RST   = 8'd75;
    localparam logic [7:0]  WAIT_LONG_RST  = 8'd100;
    localparam logic [9:0]  HYST_RST       = 10'd205;

    // dial crossings of one tick; mode index 0/1/2 = 250/500/750 thousandths,
    // interval index 0/1 = 333/667 thousandths
    typedef struct packed {
        logic       engine_on;
        logic [2:0] mode_up;
        logic [2:0] mode_dn;
        logic [1:0] int_up;
        logic [1:0] int_dn;
    } t_class;

    typedef struct packed {
        logic [14:0] pos_min;
        logic [14:0] pos_max;
        logic [11:0] step_low;
        logic [11:0] step_high;
        logic [7:0]  wait_short;
        logic [7:0]  wait_mid;
        logic [7:0]  wait_long;
    } t_cfg;

endpackage

/* src/wsc_in_if.sv */
interface wsc_in_if #(
    parameter int ADC_BITS = 12
);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] mode_sample;
    logic [ADC_BITS-1:0] interval_sample;
    logic                engine_on;

    modport source (output valid, output mode_sample, output interval_sample,
                    output engine_on, input ready);
    modport sink   (input valid, input mode_sample, input interval_sample,
                    input engine_on, output ready);
endinterface

/* src/wsc_out_if.sv */
interface wsc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] servo_position;
    logic [1:0]  mode_level;
    logic [1:0]  interval_level;
    logic [1:0]  sweep_phase;

    modport source (output valid, output servo_position, output mode_level,
                    output interval_level, output sweep_phase, input ready);
    modport sink   (input valid, input servo_position, input mode_level,
                    input interval_level, input sweep_phase, output ready);
endinterface

/* src/wsc_front.sv */
module wsc_front #(
    parameter int ADC_BITS = 12
) (
    wsc_in_if.sink         i_in,
    input  logic [9:0]     i_hysteresis,
    input  logic           i_q_full,
    output logic           o_push,
    output wsc_pkg::t_class o_class
);
    import wsc_pkg::*;

    localparam int FS = (1 << ADC_BITS) - 1;
    localparam int CW = ((ADC_BITS > 10) ? ADC_BITS : 10) + 11;
    localparam logic [CW-1:0] TH250 = CW'(250 * FS);
    localparam logic [CW-1:0] TH500 = CW'(500 * FS);
    localparam logic [CW-1:0] TH750 = CW'(750 * FS);
    localparam logic [CW-1:0] TH333 = CW'(333 * FS);
    localparam logic [CW-1:0] TH667 = CW'(667 * FS);
    localparam logic [CW-1:0] K1000 = CW'(1000);

    logic [CW-1:0] ms_k, is_k, h_k;

    assign ms_k = CW'(i_in.mode_sample) * K1000;
    assign is_k = CW'(i_in.interval_sample) * K1000;
    assign h_k  = CW'(i_hysteresis) * K1000;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        o_class.engine_on  = i_in.engine_on;
        o_class.mode_up[0] = ms_k > TH250 + h_k;
        o_class.mode_up[1] = ms_k > TH500 + h_k;
        o_class.mode_up[2] = ms_k > TH750 + h_k;
        o_class.mode_dn[0] = ms_k + h_k < TH250;
        o_class.mode_dn[1] = ms_k + h_k < TH500;
        o_class.mode_dn[2] = ms_k + h_k < TH750;
        o_class.int_up[0]  = is_k > TH333 + h_k;
        o_class.int_up[1]  = is_k > TH667 + h_k;
        o_class.int_dn[0]  = is_k + h_k < TH333;
        o_class.int_dn[1]  = is_k + h_k < TH667;
    end

endmodule

/* src/wsc_queue.sv */
module wsc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wsc_pkg::t_class i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output wsc_pkg::t_class o_data
);
    import wsc_pkg::*;

    t_class     r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop)  r_rd <= !r_rd;
            if (i_push && !i_pop)      r_count <= r_count + 2'd1;
            else if (!i_push && i_pop) r_count <= r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule

/* src/wsc_back.sv */
module wsc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wsc_pkg::t_cfg   i_cfg,
    input  logic            i_q_empty,
    input  wsc_pkg::t_class i_class,
    output logic            o_pop,
    wsc_out_if.source       o_out
);
    import wsc_pkg::*;

    logic [1:0]  r_mode, r_int, r_phase;
    logic [15:0] r_pos;
    logic [7:0]  r_wait;
    logic        r_valid;
    logic [1:0]  n_mode, n_int, n_phase;
    logic [15:0] n_pos;
    logic [7:0]  n_wait;

    function automatic logic [15:0] f_up(input logic [15:0] p, input logic [11:0] s);
        logic [16:0] sum;
        sum = {1'b0, p} + 17'(s);
        return sum[16] ? 16'hFFFF : sum[15:0];
    endfunction

    function automatic logic [15:0] f_down(input logic [15:0] p, input logic [11:0] s);
        return (p > 16'(s)) ? p - 16'(s) : 16'd0;
    endfunction

    // state doubles as the output register
    assign o_pop                = !i_q_empty && (!r_valid || o_out.ready);
    assign o_out.valid          = r_valid;
    assign o_out.servo_position = r_pos;
    assign o_out.mode_level     = r_mode;
    assign o_out.interval_level = r_int;
    assign o_out.sweep_phase    = r_phase;

    always_comb begin
        logic [11:0] step;
        logic [7:0]  lim;
        n_mode  = r_mode;
        n_int   = r_int;
        n_phase = r_phase;
        n_pos   = r_pos;
        n_wait  = r_wait;
        step    = i_cfg.step_low;
        lim     = i_cfg.wait_long;
        if (!i_class.engine_on) begin
            if (r_mode != MODE_INTERVAL) n_pos = {1'b0, i_cfg.pos_min};
        end else begin
            // rules in fixed order; one tick may climb several levels
            if (n_mode == MODE_LOW && i_class.mode_up[0]) n_mode = MODE_HIGH;
            if (n_mode == MODE_HIGH && i_class.mode_up[1]) begin
                n_wait = '0;
                n_mode = MODE_INTERVAL;
            end
            if (n_mode == MODE_HIGH && i_class.mode_dn[0]) n_mode = MODE_LOW;
            if (n_mode == MODE_INTERVAL && i_class.mode_up[2]) n_mode = MODE_OFF;
            if (n_mode == MODE_INTERVAL && i_class.mode_dn[1]) n_mode = MODE_HIGH;
            if (n_mode == MODE_OFF && i_class.mode_dn[2]) begin
                n_wait = '0;
                n_mode = MODE_INTERVAL;
            end
            if (n_int == INT_SHORT && i_class.int_up[0]) begin
                n_wait = '0;
                n_int  = INT_MID;
            end
            if (n_int == INT_MID && i_class.int_up[1]) begin
                n_wait = '0;
                n_int  = INT_LONG;
            end
            if (n_int == INT_MID && i_class.int_dn[0]) begin
                n_wait = '0;
                n_int  = INT_SHORT;
            end
            if (n_int == INT_LONG && i_class.int_dn[1]) begin
                n_wait = '0;
                n_int  = INT_MID;
            end

            if (n_mode == MODE_HIGH) step = i_cfg.step_high;
            if (n_int == INT_SHORT)    lim = i_cfg.wait_short;
            else if (n_int == INT_MID) lim = i_cfg.wait_mid;

            unique case (n_mode) inside
                MODE_LOW, MODE_HIGH: begin
                    if (n_phase == PH_RISE) begin
                        n_pos = f_up(n_pos, step);
                        if (n_pos > {1'b0, i_cfg.pos_max}) n_phase = PH_FALL;
                    end else begin
                        n_pos = f_down(n_pos, step);
                        if (n_pos < {1'b0, i_cfg.pos_min}) n_phase = PH_RISE;
                    end
                end
                MODE_INTERVAL: begin
                    if (n_phase == PH_RISE) begin
                        n_pos = f_up(n_pos, step);
                        if (n_pos > {1'b0, i_cfg.pos_max}) n_phase = PH_FALL;
                    end else if (n_phase == PH_FALL) begin
                        n_pos = f_down(n_pos, step);
                        if (n_pos < {1'b0, i_cfg.pos_min}) begin
                            n_phase = PH_STOP;
                            n_wait  = '0;
                        end
                    end else begin
                        if (n_wait != 8'hFF) n_wait = n_wait + 8'd1;
                        if (n_wait >= lim) n_phase = PH_RISE;
                    end
                end
                default: begin
                    if (n_pos > {1'b0, i_cfg.pos_min}) n_pos = {1'b0, i_cfg.pos_min};
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mode  <= MODE_LOW;
            r_int   <= INT_SHORT;
            r_phase <= PH_STOP;
            r_pos   <= {1'b0, POS_MIN_RST};
            r_wait  <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_mode  <= n_mode;
                r_int   <= n_int;
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_wait  <= n_wait;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

/* src/wiper_sweep_controller.sv */
// Wiper sweep controller: one input beat per 10 ms tick, one result beat per
// tick. Sustains one tick per clock while the output is ready. The front
// classifier is combinational and writes a two-entry queue at the accepting
// edge; the state update then takes the entry into registers that also serve
// as the output register, which presents the result beat. The single state
// update per cycle is what fixes the rate. Configuration writes take effect at
// once and must only be made while no tick is pending.
module wiper_sweep_controller #(
    parameter int ADC_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    wsc_in_if.sink                       i_in,
    wsc_out_if.source                    o_out,
    input  logic                         i_cfg_we,
    input  logic [wsc_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [wsc_pkg::CFG_DW-1:0]   i_cfg_data
);
    import wsc_pkg::*;

    t_cfg       r_cfg;
    logic [9:0] r_hyst;
    t_class     front_class, q_class;
    logic       push, q_full, q_empty, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_min    <= POS_MIN_RST;
            r_cfg.pos_max    <= POS_MAX_RST;
            r_cfg.step_low   <= STEP_LOW_RST;
            r_cfg.step_high  <= STEP_HIGH_RST;
            r_cfg.wait_short <= WAIT_SHORT_RST;
            r_cfg.wait_mid   <= WAIT_MID_RST;
            r_cfg.wait_long  <= WAIT_LONG_RST;
            r_hyst           <= HYST_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_POS_MIN:    r_cfg.pos_min    <= i_cfg_data;
                CFG_POS_MAX:    r_cfg.pos_max    <= i_cfg_data;
                CFG_STEP_LOW:   r_cfg.step_low   <= i_cfg_data[11:0];
                CFG_STEP_HIGH:  r_cfg.step_high  <= i_cfg_data[11:0];
                CFG_WAIT_SHORT: r_cfg.wait_short <= i_cfg_data[7:0];
                CFG_WAIT_MID:   r_cfg.wait_mid   <= i_cfg_data[7:0];
                CFG_WAIT_LONG:  r_cfg.wait_long  <= i_cfg_data[7:0];
                CFG_HYSTERESIS: r_hyst           <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    wsc_front #(.ADC_BITS(ADC_BITS)) u_front (
        .i_in         (i_in),
        .i_hysteresis (r_hyst),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_class      (front_class)
    );

    wsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_class),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (q_class)
    );

    wsc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_class   (q_class),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

/* src/wsc_checker.sv */
module wsc_sva_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_pos,
    input logic [1:0]  i_mode,
    input logic [1:0]  i_int,
    input logic [1:0]  i_phase
);
    import wsc_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat shown right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pos)
            && $stable(i_mode) && $stable(i_int) && $stable(i_phase))
        else $error("stalled result beat changed");

    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_phase == PH_STOP || i_phase == PH_RISE || i_phase == PH_FALL)
            && (i_int == INT_SHORT || i_int == INT_MID || i_int == INT_LONG))
        else $error("illegal phase or interval level");

    // queue only fills up behind a stalled result
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result pending");

endmodule

bind wiper_sweep_controller wsc_sva_checker u_wsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_pos       (o_out.servo_position),
    .i_mode      (o_out.mode_level),
    .i_int       (o_out.interval_level),
    .i_phase     (o_out.sweep_phase)
);
